// ===== hdl/arq_pkg.sv =====
// ----------------------------------------------------------------------------
// ARQ sender package
// Event and action codes, widths and constants shared by the sender files.
// ----------------------------------------------------------------------------
`default_nettype none

package arq_pkg;

   localparam int SEQ_W    = 32;
   localparam int TOL_W    = 9;
   localparam int FUNC_W   = 2;
   localparam int ACTION_W = 3;
   localparam int SCALE_SH = 8;
   localparam int PROD_W   = SEQ_W + TOL_W;

   localparam logic [TOL_W-1:0] TOL_RESET  = 9'd128;
   localparam logic [TOL_W-1:0] FULL_SCALE = 9'd256;
   localparam logic [SEQ_W-1:0] COUNT_MAX  = '1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CONNECT = 2'd0,
      FUNC_SEND    = 2'd1,
      FUNC_ACK     = 2'd2,
      FUNC_TIMEOUT = 2'd3
   } func_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE       = 3'd0,
      ACT_TRANSMIT   = 3'd1,
      ACT_RETRANSMIT = 3'd2,
      ACT_DELIVERED  = 3'd3,
      ACT_ABANDONED  = 3'd4,
      ACT_REJECTED   = 3'd5,
      ACT_CONNECTED  = 3'd6
   } action_type;

endpackage

`default_nettype wire

// ===== hdl/arq_if.sv =====
// ----------------------------------------------------------------------------
// ARQ sender channels
// Valid/ready channels for events, actions and the tolerance register.
// ----------------------------------------------------------------------------
`default_nettype none

interface arq_req_if import arq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [SEQ_W-1:0]    ack_number;

   modport source (output valid, output func, output ack_number, input ready);
   modport sink   (input valid, input func, input ack_number, output ready);
endinterface

interface arq_rsp_if import arq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [SEQ_W-1:0]    packet_seq;

   modport source (output valid, output action, output packet_seq, input ready);
   modport sink   (input valid, input action, input packet_seq, output ready);
endinterface

interface arq_csr_if import arq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [TOL_W-1:0]    loss_tolerance;

   modport source (output valid, output loss_tolerance, input ready);
   modport sink   (input valid, input loss_tolerance, output ready);
endinterface

`default_nettype wire

// ===== hdl/loss_tolerant_arq_sender.sv =====
// ----------------------------------------------------------------------------
// Loss-tolerant stop-and-wait ARQ sender
// Connection, sequence and delivery bookkeeping with partial reliability.
// ----------------------------------------------------------------------------
// One event is taken per clock cycle unless the action register stalls, and
// gives exactly one action, held in the event register, then in the action
// register. The link state (sequence number, saturating sent and acked
// counts, connected and waiting flags) is updated as an event moves from the
// event register to the action register, so the next event already sees it.
// A failed packet is retransmitted while acked*256 < sent*(256 - tolerance);
// write the tolerance (units of 1/256, reset 128) only while the block is idle.
`default_nettype none

module loss_tolerant_arq_sender
   import arq_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   arq_req_if.sink   req_ch,
   arq_rsp_if.source rsp_ch,
   arq_csr_if.sink   csr_ch
);

   logic             in_valid_ff;
   func_type         in_func_ff;
   logic [SEQ_W-1:0] in_ack_ff;

   logic             out_valid_ff;
   action_type       out_action_ff;
   logic [SEQ_W-1:0] out_seq_ff;

   logic [TOL_W-1:0] tolerance_ff;
   logic [SEQ_W-1:0] next_seq_ff;
   logic [SEQ_W-1:0] sent_ff;
   logic [SEQ_W-1:0] acked_ff;
   logic             connected_ff;
   logic             awaiting_ff;

   logic [SEQ_W-1:0] next_seq_in;
   logic [SEQ_W-1:0] sent_in;
   logic [SEQ_W-1:0] acked_in;
   logic             connected_in;
   logic             awaiting_in;
   action_type       action_in;
   logic [SEQ_W-1:0] seq_in;

   logic advance;
   logic retry;

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !in_valid_ff || advance;
   assign csr_ch.ready  = 1'b1;

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.action     = out_action_ff;
   assign rsp_ch.packet_seq = out_seq_ff;

   arq_retry u_retry (
      .sent_count     (sent_ff),
      .acked_count    (acked_ff),
      .loss_tolerance (tolerance_ff),
      .retry          (retry)
   );

   always_comb begin
      next_seq_in  = next_seq_ff;
      sent_in      = sent_ff;
      acked_in     = acked_ff;
      connected_in = connected_ff;
      awaiting_in  = awaiting_ff;
      action_in    = ACT_NONE;
      seq_in       = '0;
      case (in_func_ff)
         FUNC_CONNECT: begin
            connected_in = 1'b1;
            awaiting_in  = 1'b0;
            sent_in      = '0;
            acked_in     = '0;
            action_in    = ACT_CONNECTED;
         end
         FUNC_SEND: begin
            if (!connected_ff || awaiting_ff) begin
               action_in = ACT_REJECTED;
            end else begin
               seq_in      = next_seq_ff;
               next_seq_in = next_seq_ff + 1'b1;
               sent_in     = (sent_ff == COUNT_MAX) ? sent_ff : sent_ff + 1'b1;
               awaiting_in = 1'b1;
               action_in   = ACT_TRANSMIT;
            end
         end
         default: begin
            if (awaiting_ff) begin
               if (in_func_ff == FUNC_ACK && in_ack_ff == next_seq_ff) begin
                  acked_in    = (acked_ff == COUNT_MAX) ? acked_ff : acked_ff + 1'b1;
                  awaiting_in = 1'b0;
                  action_in   = ACT_DELIVERED;
               end else if (retry) begin
                  seq_in    = next_seq_ff - 1'b1;
                  action_in = ACT_RETRANSMIT;
               end else begin
                  awaiting_in = 1'b0;
                  action_in   = ACT_ABANDONED;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         tolerance_ff <= TOL_RESET;
         next_seq_ff  <= '0;
         sent_ff      <= '0;
         acked_ff     <= '0;
         connected_ff <= 1'b0;
         awaiting_ff  <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            tolerance_ff <= csr_ch.loss_tolerance;
         end
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            next_seq_ff  <= next_seq_in;
            sent_ff      <= sent_in;
            acked_ff     <= acked_in;
            connected_ff <= connected_in;
            awaiting_ff  <= awaiting_in;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_func_ff <= func_type'(req_ch.func);
         in_ack_ff  <= req_ch.ack_number;
      end
      if (advance) begin
         out_action_ff <= action_in;
         out_seq_ff    <= seq_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/arq_retry.sv =====
// ----------------------------------------------------------------------------
// ARQ retry decision
// Retry while acked*256 < sent*(256 - tolerance), tolerance clamped to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module arq_retry
   import arq_pkg::*;
(
   input  wire logic [SEQ_W-1:0] sent_count,
   input  wire logic [SEQ_W-1:0] acked_count,
   input  wire logic [TOL_W-1:0] loss_tolerance,
   output logic                  retry
);

   logic [TOL_W-1:0]  tol_clamp;
   logic [TOL_W-1:0]  factor;
   logic [PROD_W-1:0] lhs;
   logic [PROD_W-1:0] rhs;

   always_comb begin
      tol_clamp = (loss_tolerance > FULL_SCALE) ? FULL_SCALE : loss_tolerance;
      factor    = FULL_SCALE - tol_clamp;
      lhs       = {{(PROD_W-SEQ_W-SCALE_SH){1'b0}}, acked_count, {SCALE_SH{1'b0}}};
      rhs       = PROD_W'(sent_count) * PROD_W'(factor);
      retry     = lhs < rhs;
   end

endmodule

`default_nettype wire

// ===== dv/arq_sender_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARQ sender checker
// Watches the event, action and tolerance channels. It keeps its own copy of
// the link state, predicts one action per accepted event and compares each
// accepted action with the oldest prediction.
// ----------------------------------------------------------------------------

module arq_sender_checker
   import arq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   arq_req_if               req_ch,
   arq_rsp_if               rsp_ch,
   arq_csr_if               csr_ch,
   output int               fail_count,
   output int               pending,
   output logic [SEQ_W-1:0] seq_hint
);

   typedef struct packed {
      action_type       action;
      logic [SEQ_W-1:0] seq;
   } link_result_type;

   link_result_type  expected_actions[$];
   logic [TOL_W-1:0] tolerance;
   logic [SEQ_W-1:0] next_seq;
   logic [SEQ_W-1:0] sent_count;
   logic [SEQ_W-1:0] acked_count;
   logic             connected;
   logic             awaiting_ack;

   function automatic logic [SEQ_W-1:0] bump(logic [SEQ_W-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic retry_allowed();
      logic [TOL_W-1:0] tol_eff;
      logic [63:0]      lhs;
      logic [63:0]      rhs;
      tol_eff = (tolerance > FULL_SCALE) ? FULL_SCALE : tolerance;
      lhs = 64'(acked_count) << SCALE_SH;
      rhs = 64'(sent_count) * 64'(FULL_SCALE - tol_eff);
      return lhs < rhs;
   endfunction

   function automatic link_result_type predict_action(func_type f, logic [SEQ_W-1:0] ackn);
      link_result_type r;
      r.action = ACT_NONE;
      r.seq    = '0;
      case (f)
         FUNC_CONNECT: begin
            connected    = 1'b1;
            awaiting_ack = 1'b0;
            sent_count   = '0;
            acked_count  = '0;
            r.action     = ACT_CONNECTED;
         end
         FUNC_SEND: begin
            if (!connected || awaiting_ack) begin
               r.action = ACT_REJECTED;
            end else begin
               r.action     = ACT_TRANSMIT;
               r.seq        = next_seq;
               next_seq     = next_seq + 1'b1;
               sent_count   = bump(sent_count);
               awaiting_ack = 1'b1;
            end
         end
         default: begin
            if (awaiting_ack) begin
               if (f == FUNC_ACK && ackn == next_seq) begin
                  acked_count  = bump(acked_count);
                  awaiting_ack = 1'b0;
                  r.action     = ACT_DELIVERED;
               end else if (retry_allowed()) begin
                  r.action = ACT_RETRANSMIT;
                  r.seq    = next_seq - 1'b1;
               end else begin
                  awaiting_ack = 1'b0;
                  r.action     = ACT_ABANDONED;
               end
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      link_result_type exp_r;
      if (reset) begin
         expected_actions.delete();
         tolerance    = TOL_RESET;
         next_seq     = '0;
         sent_count   = '0;
         acked_count  = '0;
         connected    = 1'b0;
         awaiting_ack = 1'b0;
         fail_count   = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_actions.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected action %0d packet_seq %0h, expected none",
                        $time, rsp_ch.action, rsp_ch.packet_seq);
            end else begin
               exp_r = expected_actions.pop_front();
               if (rsp_ch.action !== exp_r.action) begin
                  fail_count++;
                  $display("%0t: action expected %0d got %0d",
                           $time, exp_r.action, rsp_ch.action);
               end
               if (rsp_ch.packet_seq !== exp_r.seq) begin
                  fail_count++;
                  $display("%0t: packet_seq expected %0h got %0h",
                           $time, exp_r.seq, rsp_ch.packet_seq);
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            tolerance = csr_ch.loss_tolerance;
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_actions.push_back(
               predict_action(func_type'(req_ch.func), req_ch.ack_number));
         end
      end
      pending  = expected_actions.size();
      seq_hint = next_seq;
   end

endmodule

// ===== dv/tb_loss_tolerant_arq_sender.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Loss-tolerant ARQ sender testbench
// Drives connect, send, ack and timeout events with random gaps on both
// channels, walks the loss tolerance through its extremes between phases and
// leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------

module tb_loss_tolerant_arq_sender;
   import arq_pkg::*;

   localparam int LONG_HOLD   = 300;
   localparam int IDLE_LIMIT  = 4000;
   localparam int DRAIN       = 8;
   localparam int PHASE_ITEMS = 250;

   logic             clock;
   logic             reset;
   int               fail_count;
   int               pending;
   logic [SEQ_W-1:0] seq_hint;
   logic             steady;
   logic             hold_off_req;
   int               idle_cycles = 0;
   int               item_count;
   logic [TOL_W-1:0] tol_plan[8];

   arq_req_if req_ch ();
   arq_rsp_if rsp_ch ();
   arq_csr_if csr_ch ();

   loss_tolerant_arq_sender i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   arq_sender_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .fail_count (fail_count),
      .pending    (pending),
      .seq_hint   (seq_hint)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic int rand_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_item(func_type f, logic [SEQ_W-1:0] ackn, bit rel);
      int gap;
      @(negedge clock);
      req_ch.valid      <= 1'b1;
      req_ch.func       <= f;
      req_ch.ack_number <= rel ? seq_hint + ackn : ackn;
      do @(posedge clock); while (!req_ch.ready);
      item_count++;
      gap = steady ? 0 : rand_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_tolerance(logic [TOL_W-1:0] v);
      @(negedge clock);
      csr_ch.valid          <= 1'b1;
      csr_ch.loss_tolerance <= v;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain_link();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   task automatic run_random(int target);
      int stop_at;
      int n_fail;
      stop_at = item_count + target;
      while (item_count < stop_at) begin
         case ($urandom_range(0, 19))
            0: send_item(FUNC_CONNECT, $urandom, 1'b0);
            1, 2: send_item(func_type'($urandom_range(0, 3)), $urandom, 1'b0);
            3: send_item(FUNC_ACK, 32'($urandom_range(0, 2)), 1'b1);
            default: begin
               send_item(FUNC_SEND, $urandom, 1'b0);
               n_fail = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
               repeat (n_fail) begin
                  if ($urandom_range(0, 1)) begin
                     send_item(FUNC_TIMEOUT, $urandom, 1'b0);
                  end else begin
                     send_item(FUNC_ACK, $urandom_range(0, 1) ? 32'hFFFF_FFFF
                               : 32'($urandom_range(1, 3)), 1'b1);
                  end
               end
               if ($urandom_range(0, 3) != 0) send_item(FUNC_ACK, '0, 1'b1);
            end
         endcase
      end
   endtask

   // receiver: random gaps, steady stretches, one long hold-off on request
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (steady) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            gap = rand_gap();
            if (gap == 0) begin
               rsp_ch.ready <= 1'b1;
            end else begin
               rsp_ch.ready <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL loss_tolerant_arq_sender");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset                 = 1'b1;
      steady                = 1'b0;
      hold_off_req          = 1'b0;
      item_count            = 0;
      req_ch.valid          = 1'b0;
      req_ch.func           = FUNC_CONNECT;
      req_ch.ack_number     = '0;
      csr_ch.valid          = 1'b0;
      csr_ch.loss_tolerance = TOL_RESET;
      tol_plan = '{9'd0, 9'd256, 9'd511, 9'd257, 9'd1, 9'd255, 9'd128, 9'd0};
      tol_plan[7] = TOL_W'($urandom_range(0, 511));
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(FUNC_SEND,    32'h0,         1'b0);
      send_item(FUNC_ACK,     32'h0,         1'b0);
      send_item(FUNC_TIMEOUT, 32'hFFFF_FFFF, 1'b0);
      send_item(FUNC_CONNECT, 32'h0,         1'b0);
      send_item(FUNC_SEND,    32'h0,         1'b0);
      send_item(FUNC_SEND,    32'h0,         1'b0);
      send_item(FUNC_ACK,     32'h5,         1'b0);
      send_item(FUNC_TIMEOUT, 32'h0,         1'b0);
      send_item(FUNC_ACK,     32'h1,         1'b0);
      send_item(FUNC_ACK,     32'h1,         1'b0);
      send_item(FUNC_SEND,    32'h0,         1'b0);
      send_item(FUNC_ACK,     32'h2,         1'b0);
      send_item(FUNC_SEND,    32'h0,         1'b0);
      send_item(FUNC_TIMEOUT, 32'h0,         1'b0);
      send_item(FUNC_TIMEOUT, 32'h0,         1'b0);
      send_item(FUNC_SEND,    32'h0,         1'b0);
      send_item(FUNC_ACK,     32'hFFFF_FFFF, 1'b0);
      send_item(FUNC_SEND,    32'h0,         1'b0);
      send_item(FUNC_ACK,     32'h0,         1'b0);
      send_item(FUNC_CONNECT, 32'h0,         1'b0);
      send_item(FUNC_CONNECT, 32'hFFFF_FFFF, 1'b0);
      send_item(FUNC_SEND,    32'hFFFF_FFFF, 1'b0);
      send_item(FUNC_ACK,     32'h6,         1'b0);
      drain_link();

      foreach (tol_plan[p]) begin
         write_tolerance(tol_plan[p]);
         steady = (p % 3 == 1);
         if (p == 2) hold_off_req = 1'b1;
         run_random(PHASE_ITEMS);
         drain_link();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("PASS loss_tolerant_arq_sender");
      end else begin
         $display("FAIL loss_tolerant_arq_sender");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/arq_pkg.sv
hdl/arq_if.sv
hdl/arq_retry.sv
hdl/loss_tolerant_arq_sender.sv
dv/arq_sender_checker.sv
dv/tb_loss_tolerant_arq_sender.sv
